FILE: hdl/mandelbrot_escape_time_macros.svh
// Assertion macros for the escape-time block.
// Used by hdl/mbe_ctrl.sv; expects clk_i and rst_ni in scope.
`ifndef MANDELBROT_ESCAPE_TIME_MACROS_SVH
`define MANDELBROT_ESCAPE_TIME_MACROS_SVH

`ifndef NO_ASSERTIONS

// Plain property, checked at every rising clock edge outside reset.
`define MBE_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// Same-cycle implication.
`define MBE_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("implication failed");

// Next-cycle implication.
`define MBE_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`else

`define MBE_ASSERT(name, prop)
`define MBE_ASSERT_IMP(name, ante, cons)
`define MBE_ASSERT_NEXT(name, ante, cons)

`endif

`endif

FILE: hdl/mbe_pkg.sv
// Shared constants and controller/datapath interface types for the
// escape-time block. No dependencies.
package mbe_pkg;

  localparam int unsigned WORD_BITS  = 32;
  localparam int unsigned FRAC_BITS  = 27;
  localparam int unsigned COUNT_BITS = 12;

  localparam logic [COUNT_BITS-1:0] MAX_ITER_RESET = COUNT_BITS'(511);

  // full-width product, sum of squares, and widened update sum
  localparam int unsigned PROD_W = 2 * WORD_BITS;
  localparam int unsigned SQ_W   = PROD_W + 1;
  localparam int unsigned SUM_W  = PROD_W + 2;

  // |z|^2 < 4 in Q(2F) is sum < 2^(2F+2)
  localparam logic [SQ_W-1:0] ESC_LIMIT = SQ_W'(1) << (2 * FRAC_BITS + 2);

  localparam logic signed [SUM_W-1:0] SAT_MAX = (SUM_W'(1) <<< (WORD_BITS - 1)) - SUM_W'(1);
  localparam logic signed [SUM_W-1:0] SAT_MIN = -(SUM_W'(1) <<< (WORD_BITS - 1));

  typedef struct packed {
    logic load;    // capture c, z <= c
    logic mul;     // register x*x, y*y, x*y
    logic update;  // z <= z^2 + c
  } dp_cmd_t;

  typedef struct packed {
    logic escaped; // |z|^2 >= 4 on the registered products
  } dp_sts_t;

endpackage

FILE: hdl/mbe_datapath.sv
// Fixed-point iteration datapath: three multipliers, escape compare, update.
// Depends on mbe_pkg.
module mbe_datapath (
  input  logic                                 clk_i,
  input  logic signed [mbe_pkg::WORD_BITS-1:0] point_real_i,
  input  logic signed [mbe_pkg::WORD_BITS-1:0] point_imag_i,
  input  mbe_pkg::dp_cmd_t                     cmd_i,
  output mbe_pkg::dp_sts_t                     sts_o
);
  import mbe_pkg::*;

  logic signed [WORD_BITS-1:0] cx_q, cy_q, x_q, y_q;
  logic signed [WORD_BITS-1:0] x_d, y_d;
  logic signed [PROD_W-1:0]    xx_q, yy_q, xy_q;
  logic signed [PROD_W-1:0]    xe, ye;
  logic [SQ_W-1:0]             mag_sq;
  logic signed [SUM_W-1:0]     re_sum, im_sum;

  assign xe = PROD_W'(x_q);
  assign ye = PROD_W'(y_q);

  // squares are non-negative, so the sum fits unsigned in one extra bit
  assign mag_sq = {1'b0, xx_q} + {1'b0, yy_q};
  assign sts_o.escaped = (mag_sq >= ESC_LIMIT);

  // arithmetic shifts give floor rounding; x*y shifted one less doubles it
  assign re_sum = SUM_W'(xx_q >>> FRAC_BITS) - SUM_W'(yy_q >>> FRAC_BITS) + SUM_W'(cx_q);
  assign im_sum = SUM_W'(xy_q >>> (FRAC_BITS - 1)) + SUM_W'(cy_q);

  always_comb begin
    if (re_sum > SAT_MAX) begin
      x_d = SAT_MAX[WORD_BITS-1:0];
    end else if (re_sum < SAT_MIN) begin
      x_d = SAT_MIN[WORD_BITS-1:0];
    end else begin
      x_d = re_sum[WORD_BITS-1:0];
    end
    if (im_sum > SAT_MAX) begin
      y_d = SAT_MAX[WORD_BITS-1:0];
    end else if (im_sum < SAT_MIN) begin
      y_d = SAT_MIN[WORD_BITS-1:0];
    end else begin
      y_d = im_sum[WORD_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cx_q <= point_real_i;
      cy_q <= point_imag_i;
      x_q  <= point_real_i;
      y_q  <= point_imag_i;
    end else if (cmd_i.update) begin
      x_q <= x_d;
      y_q <= y_d;
    end
    if (cmd_i.mul) begin
      xx_q <= xe * xe;
      yy_q <= ye * ye;
      xy_q <= xe * ye;
    end
  end

endmodule

FILE: hdl/mbe_ctrl.sv
// Sequencer for the escape-time block: iteration counter, limit register,
// input handshake and result register. Depends on mbe_pkg and the macros header.
`include "mandelbrot_escape_time_macros.svh"

module mbe_ctrl (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [mbe_pkg::COUNT_BITS-1:0]        cfg_wdata_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [mbe_pkg::COUNT_BITS-1:0]        iteration_count_o,
  output mbe_pkg::dp_cmd_t                      cmd_o,
  input  mbe_pkg::dp_sts_t                      sts_i
);
  import mbe_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_EVAL
  } state_e;

  state_e                state_q, state_d;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d;
  logic [COUNT_BITS-1:0] max_iter_q, max_iter_d;
  logic                  out_valid_q, out_valid_d;
  logic [COUNT_BITS-1:0] out_count_q, out_count_d;
  logic                  in_xfer, out_free, finish;

  assign in_stall_o        = (state_q != ST_IDLE);
  assign in_xfer           = in_valid_i && !in_stall_o;
  assign out_valid_o       = out_valid_q;
  assign iteration_count_o = out_count_q;
  assign out_free          = !out_valid_q || !out_stall_i;
  assign finish            = sts_i.escaped || (cnt_q == max_iter_q);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    max_iter_d  = cfg_we_i ? cfg_wdata_i : max_iter_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_count_d = out_count_q;
    cmd_o       = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_EVAL;
      end
      ST_EVAL: begin
        if (finish) begin
          // hold here until the result register can take the count
          if (out_free) begin
            out_valid_d = 1'b1;
            out_count_d = cnt_q;
            state_d     = ST_IDLE;
          end
        end else begin
          cmd_o.update = 1'b1;
          cnt_d        = cnt_q + 1'b1;
          state_d      = ST_MUL;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      max_iter_q  <= MAX_ITER_RESET;
      out_valid_q <= 1'b0;
      out_count_q <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      max_iter_q  <= max_iter_d;
      out_valid_q <= out_valid_d;
      out_count_q <= out_count_d;
    end
  end

  `MBE_ASSERT_NEXT(a_accept_starts_mul, in_xfer, state_q == ST_MUL)
  `MBE_ASSERT_NEXT(a_mul_then_eval, state_q == ST_MUL, state_q == ST_EVAL)
  `MBE_ASSERT_IMP(a_result_on_finish, $rose(out_valid_q), $past(state_q == ST_EVAL && finish))

endmodule

FILE: hdl/mandelbrot_escape_time.sv
// Mandelbrot escape-time counter, top level.
// Depends on mbe_pkg, mbe_ctrl and mbe_datapath.
//
// One point c = (point_real_i, point_imag_i) in signed Q5.27 is taken per
// transfer and one iteration_count_o comes back. Each iteration runs
// through ST_MUL, which registers x*x, y*y and x*y from three 32x32
// multipliers, and then ST_EVAL, which does the escape compare and the
// saturated z^2 + c update. The multiply/evaluate loop sets how long a
// point occupies the block; the count and a stalled output extend it.
// A new point is taken as soon as the previous one finishes, even while its
// result still waits in the output register. max_iterations (cfg_wdata_i,
// reset 511) is to be written only while the block is idle.
module mandelbrot_escape_time (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [mbe_pkg::COUNT_BITS-1:0]       cfg_wdata_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [mbe_pkg::WORD_BITS-1:0] point_real_i,
  input  logic signed [mbe_pkg::WORD_BITS-1:0] point_imag_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [mbe_pkg::COUNT_BITS-1:0]       iteration_count_o
);
  import mbe_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  mbe_ctrl u_ctrl (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .iteration_count_o (iteration_count_o),
    .cmd_o             (cmd),
    .sts_i             (sts)
  );

  mbe_datapath u_datapath (
    .clk_i        (clk_i),
    .point_real_i (point_real_i),
    .point_imag_i (point_imag_i),
    .cmd_i        (cmd),
    .sts_o        (sts)
  );

endmodule
